[sv/mtp_pkg.sv]
package mtp_pkg;

  localparam int unsigned NumWords    = 624;
  localparam int unsigned ShiftWords  = 397;
  localparam int unsigned IdxW        = $clog2(NumWords);

  localparam logic [31:0] Matrix      = 32'h9908_b0df;
  localparam logic [31:0] UpperMask   = 32'h8000_0000;
  localparam logic [31:0] LowerMask   = 32'h7fff_ffff;
  localparam logic [31:0] TemperB     = 32'h9d2c_5680;
  localparam logic [31:0] TemperC     = 32'hefc6_0000;
  localparam logic [31:0] InitMult    = 32'd1812433253;
  localparam logic [31:0] DefaultSeed = 32'd4357;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumWords - 1);

  typedef enum logic {
    OpDraw = 1'b0,
    OpSeed = 1'b1
  } op_e;

  typedef enum logic {
    StFill,
    StReady
  } state_e;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [31:0]     data;
  } mem_wr_t;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] p);
    next_idx = (p == LastIdx) ? '0 : p + IdxW'(1);
  endfunction

  // (p + 397) mod 624, p < 624 so one conditional subtract suffices
  function automatic logic [IdxW-1:0] far_idx(input logic [IdxW-1:0] p);
    logic [IdxW:0] s;
    s = {1'b0, p} + (IdxW+1)'(ShiftWords);
    if (s >= (IdxW+1)'(NumWords)) begin
      s = s - (IdxW+1)'(NumWords);
    end
    far_idx = s[IdxW-1:0];
  endfunction

  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] v;
    y = (cur & UpperMask) | (nxt & LowerMask);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ Matrix;
    end
    twist_word = v;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] k;
    k = w;
    k = k ^ (k >> 11);
    k = k ^ ((k << 7) & TemperB);
    k = k ^ ((k << 15) & TemperC);
    k = k ^ (k >> 18);
    temper = k;
  endfunction

endpackage

[sv/mtp_mem.sv]
module mtp_mem (
  input  logic                          clk_i,
  input  mtp_pkg::mem_wr_t              wr_i,
  input  logic [mtp_pkg::IdxW-1:0]      rd_addr_a_i,
  input  logic [mtp_pkg::IdxW-1:0]      rd_addr_b_i,
  output logic [31:0]                   rd_data_a_o,
  output logic [31:0]                   rd_data_b_o
);

  logic [31:0] mem_q [mtp_pkg::NumWords];
  logic [31:0] rd_a_q;
  logic [31:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[rd_addr_a_i];
    rd_b_q <= mem_q[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

[sv/mtp_seed.sv]
module mtp_seed (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      seed_i,
  output logic             busy_o,
  output logic             done_o,
  output mtp_pkg::mem_wr_t wr_o
);

  logic                     busy_q, busy_d;
  logic [mtp_pkg::IdxW-1:0] idx_q, idx_d;
  logic [31:0]              seed_q, seed_d;
  logic [31:0]              prev_q, prev_d;
  logic [31:0]              mixed;
  logic [31:0]              word;

  // x[i] = 1812433253 * (x[i-1] ^ (x[i-1] >> 30)) + i, low 32 bits
  assign mixed = prev_q ^ (prev_q >> 30);
  assign word  = (idx_q == '0) ? seed_q
                               : (mixed * mtp_pkg::InitMult) + 32'(idx_q);

  assign done_o = busy_q && (idx_q == mtp_pkg::LastIdx);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    seed_d = seed_q;
    prev_d = prev_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      seed_d = (seed_i == '0) ? mtp_pkg::DefaultSeed : seed_i;
    end else if (busy_q) begin
      prev_d = word;
      idx_d  = idx_q + mtp_pkg::IdxW'(1);
      if (done_o) begin
        busy_d = 1'b0;
        idx_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      seed_q <= mtp_pkg::DefaultSeed;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      seed_q <= seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

  assign busy_o  = busy_q;
  assign wr_o.en   = busy_q && !start_i;
  assign wr_o.addr = idx_q;
  assign wr_o.data = word;

endmodule

[sv/mersenne_twister_prng_unit.sv]
// Channel | Handshake                       | Payload
// input   | in_valid_i / in_stall_o         | operation_i, seed_i
// output  | out_valid_o / out_stall_i       | value_o
//
// A draw's result is registered in the output register. Draws can follow each
// other every cycle; a held result there stalls only draws. The twist is done
// one word per draw: the memory's two read ports prefetch the next and the far
// word for the current position, and the twisted word is written back. A reseed
// writes one word per cycle through the seed multiplier; after reset the same
// fill runs with seed 4357, and in_stall_o is high throughout.
module mersenne_twister_prng_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o
);

  mtp_pkg::state_e          state_q, state_d;
  logic [mtp_pkg::IdxW-1:0] pos_q, pos_d;
  logic [31:0]              cur_q, cur_d;
  logic                     out_valid_q, out_valid_d;
  logic [31:0]              out_value_q, out_value_d;

  logic                     accept;
  logic                     draw_acc;
  logic                     seed_acc;
  logic                     out_full;
  logic                     fill_busy;
  logic                     fill_done;
  mtp_pkg::mem_wr_t         fill_wr;
  mtp_pkg::mem_wr_t         mem_wr;
  logic [31:0]              rd_a;
  logic [31:0]              rd_b;
  logic [31:0]              twisted;

  assign out_full   = out_valid_q && out_stall_i;
  assign in_stall_o = (state_q != mtp_pkg::StReady) ||
                      (out_full && (operation_i == mtp_pkg::OpDraw));
  assign accept     = in_valid_i && !in_stall_o;
  assign draw_acc   = accept && (operation_i == mtp_pkg::OpDraw);
  assign seed_acc   = accept && (operation_i == mtp_pkg::OpSeed);

  assign twisted = mtp_pkg::twist_word(cur_q, rd_a, rd_b);

  mtp_seed u_seed (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(seed_acc),
    .seed_i (seed_i),
    .busy_o (fill_busy),
    .done_o (fill_done),
    .wr_o   (fill_wr)
  );

  always_comb begin
    if (fill_busy) begin
      mem_wr = fill_wr;
    end else begin
      mem_wr.en   = draw_acc;
      mem_wr.addr = pos_q;
      mem_wr.data = twisted;
    end
  end

  // read addresses follow the next position so the read data matches pos_q
  mtp_mem u_mem (
    .clk_i      (clk_i),
    .wr_i       (mem_wr),
    .rd_addr_a_i(mtp_pkg::next_idx(pos_d)),
    .rd_addr_b_i(mtp_pkg::far_idx(pos_d)),
    .rd_data_a_o(rd_a),
    .rd_data_b_o(rd_b)
  );

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      mtp_pkg::StFill: begin
        pos_d = '0;
        if (fill_wr.en && (fill_wr.addr == '0)) begin
          cur_d = fill_wr.data;
        end
        if (fill_done) begin
          state_d = mtp_pkg::StReady;
        end
      end
      mtp_pkg::StReady: begin
        if (seed_acc) begin
          state_d = mtp_pkg::StFill;
          pos_d   = '0;
        end else if (draw_acc) begin
          cur_d       = rd_a;
          pos_d       = mtp_pkg::next_idx(pos_q);
          out_valid_d = 1'b1;
          out_value_d = mtp_pkg::temper(twisted);
        end
      end
      default: begin
        state_d = mtp_pkg::StFill;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtp_pkg::StFill;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;

endmodule

[tb/tb_mersenne_twister_prng_unit.sv]
module tb_mersenne_twister_prng_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mtp_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int HoldCycles = 300;
  localparam int TailCycles = 16;

  typedef struct packed {
    op_e         op;
    logic [31:0] seed;
    logic        typed;
    logic [31:0] value;
  } dir_row_t;

  // Rows with typed values use the well-known MT19937 outputs for seeds 5489 and 1.
  localparam int NumDirRows = 20;
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{OpDraw, 32'h0000_0000, 1'b0, 32'h0},  // first draw after reset, twist of default state
    '{OpDraw, 32'hffff_ffff, 1'b0, 32'h0},  // seed field ignored on draws
    '{OpDraw, 32'ha5a5_5a5a, 1'b0, 32'h0},
    '{OpSeed, 32'd5489,      1'b0, 32'h0},
    '{OpDraw, 32'h0000_0000, 1'b1, 32'hd091_bb5c},
    '{OpDraw, 32'h0000_0000, 1'b1, 32'h22ae_9ef6},
    '{OpSeed, 32'd1,         1'b0, 32'h0},
    '{OpDraw, 32'hffff_ffff, 1'b1, 32'h6ac1_f425},
    '{OpDraw, 32'h0000_0000, 1'b1, 32'hff47_80eb},
    '{OpSeed, 32'h0000_0000, 1'b0, 32'h0},  // zero seed falls back to default
    '{OpDraw, 32'h0000_0000, 1'b0, 32'h0},
    '{OpSeed, 32'hffff_ffff, 1'b0, 32'h0},
    '{OpDraw, 32'h0000_0000, 1'b0, 32'h0},
    '{OpDraw, 32'h1234_5678, 1'b0, 32'h0},
    '{OpSeed, 32'd4357,      1'b0, 32'h0},
    '{OpDraw, 32'h0000_0000, 1'b0, 32'h0},
    '{OpSeed, 32'h8000_0000, 1'b0, 32'h0},  // back-to-back reseeds
    '{OpSeed, 32'h7fff_ffff, 1'b0, 32'h0},
    '{OpDraw, 32'h0000_0000, 1'b0, 32'h0},
    '{OpSeed, 32'h5a5a_a5a5, 1'b0, 32'h0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  op_e         operation_i = OpDraw;
  logic [31:0] seed_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [31:0] value_o;

  // travels with the payload so the monitor can pick up a typed value
  logic        row_typed   = 1'b0;
  logic [31:0] row_value   = '0;

  logic [31:0] mt_words [NumWords];
  int unsigned mt_pos;
  logic [31:0] pending_values [$];

  int errors       = 0;
  int quiet_cycles = 0;
  int draws_left   = 700;
  bit calm         = 1'b0;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;

  mersenne_twister_prng_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void mt_fill(input logic [31:0] s);
    logic [31:0] w;
    w = (s == '0) ? DefaultSeed : s;
    mt_words[0] = w;
    for (int i = 1; i < NumWords; i++) begin
      w = InitMult * (w ^ (w >> 30)) + 32'(i);
      mt_words[i] = w;
    end
    mt_pos = NumWords;
  endfunction

  function automatic void mt_regen();
    logic [31:0] y;
    for (int k = 0; k < NumWords; k++) begin
      y = (mt_words[k] & UpperMask) | (mt_words[(k + 1) % NumWords] & LowerMask);
      mt_words[k] = mt_words[(k + ShiftWords) % NumWords] ^ (y >> 1)
                    ^ (y[0] ? Matrix : 32'h0);
    end
    mt_pos = 0;
  endfunction

  function automatic logic [31:0] mt_draw();
    logic [31:0] k;
    if (mt_pos >= NumWords) mt_regen();
    k = mt_words[mt_pos];
    k = k ^ (k >> 11);
    k = k ^ ((k << 7) & TemperB);
    k = k ^ ((k << 15) & TemperC);
    k = k ^ (k >> 18);
    mt_pos++;
    return k;
  endfunction

  task automatic send_beat(input op_e op, input logic [31:0] s,
                           input logic typed, input logic [31:0] lit);
    if (!calm) begin
      while ($urandom_range(99) < 34) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    seed_i      <= s;
    row_typed   <= typed;
    row_value   <= lit;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // runs of draws separated by reseeds; long runs cross one or two twists
  task automatic send_random(input int count);
    logic [31:0] s;
    for (int n = 0; n < count; n++) begin
      if (draws_left == 0) begin
        draws_left = ($urandom_range(3) == 0) ? $urandom_range(625, 1300)
                                              : $urandom_range(40);
        case ($urandom_range(7))
          0:       s = '0;
          1:       s = '1;
          default: s = $urandom;
        endcase
        send_beat(OpSeed, s, 1'b0, '0);
      end else begin
        draws_left--;
        send_beat(OpDraw, $urandom, 1'b0, '0);
      end
    end
  endtask

  task automatic drain_pending();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_values.size() != 0);
  endtask

  initial begin
    mt_fill(DefaultSeed);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirRows[r]) begin
      send_beat(DirRows[r].op, DirRows[r].seed, DirRows[r].typed, DirRows[r].value);
    end

    send_random(600);
    calm = 1'b1;
    send_random(300);
    calm = 1'b0;
    hold_req = 1'b1;
    send_random(300);
    drain_pending();
    send_random(450);

    drain_pending();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver side: random stalls, a quiet stretch, and one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 34);
      end
    end
  end

  always @(posedge clk_i) begin : check_values
    logic [31:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_values.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, value_o);
          errors++;
        end else begin
          want = pending_values.pop_front();
          if (value_o !== want) begin
            $display("%0t: value mismatch, expected %h, actual %h", $time, want, value_o);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (operation_i == OpSeed) begin
          mt_fill(seed_i);
        end else begin
          want = mt_draw();
          if (row_typed) want = row_value;
          pending_values.push_back(want);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
